/* sv/dddw_pkg.sv */
package dddw_pkg;

  localparam int unsigned DIGIT_COUNT = 8;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned CODE_W  = 8;

  localparam logic [3:0]        CODE_ZERO  = 4'd0;
  localparam logic [3:0]        CODE_BLANK = 4'd15;
  localparam logic [3:0]        DIGIT_MAX  = 4'd9;

  // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
  localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int unsigned        RECIP_SHIFT = 35;

  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] rest;
    logic [POS_W-1:0]   point;
    logic               exhausted;
  } cell_t;

  typedef struct packed {
    logic              valid;
    logic [POS_W-1:0]  digit_register;
    logic [CODE_W-1:0] segment_code;
    logic              last_write;
  } res_t;

endpackage

/* sv/dddw_if.sv */
interface dddw_in_if import dddw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic [POS_W-1:0]   point_position;

  modport source (output valid, value, point_position, input ready);
  modport sink   (input valid, value, point_position, output ready);
endinterface

interface dddw_out_if import dddw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  digit_register;
  logic [CODE_W-1:0] segment_code;
  logic              last_write;

  modport source (output valid, digit_register, segment_code, last_write, input ready);
  modport sink   (input valid, digit_register, segment_code, last_write, output ready);
endinterface

/* sv/dddw_cell.sv */
// One decimal position: holds the remaining quotient, emits its digit and
// hands the quotient by ten to the next cell.
module dddw_cell import dddw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [POS_W-1:0] pos_i,
  input  cell_t            cell_i,
  output cell_t            cell_o,
  output res_t             res_o
);

  logic                 valid_q;
  logic [VALUE_W-1:0]   rest_q;
  logic [POS_W-1:0]     point_q;
  logic                 exh_q;

  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   quot;
  logic [3:0]           ten_quot;
  logic [3:0]           rem;
  logic [3:0]           digit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rest_q  <= cell_i.rest;
      point_q <= cell_i.point;
      exh_q   <= cell_i.exhausted;
    end
  end

  always_comb begin
    prod     = (2*VALUE_W)'(rest_q) * (2*VALUE_W)'(RECIP_TEN);
    quot     = VALUE_W'(prod >> RECIP_SHIFT);
    // remainder is below ten, so four bits of rest - 10*quot suffice
    ten_quot = {quot[0], 3'b000} + {quot[2:0], 1'b0};
    rem      = rest_q[3:0] - ten_quot;
    if (exh_q) begin
      digit = (pos_i <= point_q) ? CODE_ZERO : CODE_BLANK;
    end else begin
      digit = rem;
    end
  end

  assign cell_o.valid     = valid_q;
  assign cell_o.rest      = quot;
  assign cell_o.point     = point_q;
  assign cell_o.exhausted = exh_q | (quot == '0);

  assign res_o.valid          = valid_q;
  assign res_o.digit_register = pos_i;
  assign res_o.segment_code   = {(pos_i == point_q), 3'b000, digit};
  assign res_o.last_write     = (pos_i == POS_W'(DIGIT_COUNT));

endmodule

/* sv/decimal_digit_display_writer.sv */
// Channel   Dir  Payload                                       Moves
// in_i      in   value[31:0], point_position[3:0]              one request
// out_o     out  digit_register[3:0], segment_code[7:0],       one digit write
//                last_write
//
// Each request yields DIGIT_COUNT (8) digit writes, one per cycle unless out_o
// stalls; only one request lives in the chain. out_o.valid rises once the
// request has passed cell 0's register and the output register; a stall on
// out_o can hold it back.
// Reset (rst_ni low, async) empties the cell chain and the output register.
// A stall on out_o freezes the whole chain; a request may enter while the
// last digit of the previous one is still in flight.
module decimal_digit_display_writer import dddw_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  dddw_in_if.sink        in_i,
  dddw_out_if.source     out_o
);

  // cell k handles position k+1; a request walks the chain one cell a cycle while adv is high
  cell_t chain [DIGIT_COUNT+1];
  res_t  res   [DIGIT_COUNT];

  logic  adv;
  logic  early_busy;
  res_t  res_sel;

  logic              out_valid_q;
  logic [POS_W-1:0]  out_reg_q;
  logic [CODE_W-1:0] out_code_q;
  logic              out_last_q;

  // chain moves whenever the output register is free or being drained
  assign adv = !out_valid_q || out_o.ready;

  // only one request lives in the chain, so outputs never collide;
  // the last cell may still hold one since it leaves on the same edge
  always_comb begin
    early_busy = 1'b0;
    for (int k = 0; k < int'(DIGIT_COUNT) - 1; k++) begin
      early_busy = early_busy | res[k].valid;
    end
  end

  assign in_i.ready = adv && !early_busy;

  assign chain[0].valid     = in_i.valid && in_i.ready;
  assign chain[0].rest      = in_i.value;
  assign chain[0].point     = in_i.point_position;
  assign chain[0].exhausted = 1'b0;

  for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_cell
    dddw_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .pos_i  (POS_W'(k + 1)),
      .cell_i (chain[k]),
      .cell_o (chain[k+1]),
      .res_o  (res[k])
    );
  end

  // at most one cell is valid: gate and OR
  always_comb begin
    res_sel = '0;
    for (int k = 0; k < int'(DIGIT_COUNT); k++) begin
      res_sel = res_sel | (res[k] & {$bits(res_t){res[k].valid}});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= res_sel.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_reg_q  <= res_sel.digit_register;
      out_code_q <= res_sel.segment_code;
      out_last_q <= res_sel.last_write;
    end
  end

  // last cell's quotient is not needed downstream
  logic unused_tail;
  assign unused_tail = ^chain[DIGIT_COUNT];

  assign out_o.valid          = out_valid_q;
  assign out_o.digit_register = out_reg_q;
  assign out_o.segment_code   = out_code_q;
  assign out_o.last_write     = out_last_q;

endmodule

/* sv/dddw_checker.sv */
module dddw_checker import dddw_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [POS_W-1:0]  out_digit_register_i,
  input logic [CODE_W-1:0] out_segment_code_i,
  input logic              out_last_write_i
);

  // a run of writes has no gaps and counts up by one
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_write_i |=>
      out_valid_i && (out_digit_register_i == $past(out_digit_register_i) + 4'd1))
    else $error("digit run broken");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_last_write_i == (out_digit_register_i == POS_W'(DIGIT_COUNT))))
    else $error("last_write does not match final digit register");

  a_code_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_segment_code_i[6:4] == 3'b000) &&
      ((out_segment_code_i[3:0] <= DIGIT_MAX) || (out_segment_code_i[3:0] == CODE_BLANK)))
    else $error("illegal segment code");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable(out_digit_register_i) && $stable(out_segment_code_i))
    else $error("stalled output changed");

endmodule

bind decimal_digit_display_writer dddw_checker u_dddw_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .out_valid_i          (out_o.valid),
  .out_ready_i          (out_o.ready),
  .out_digit_register_i (out_o.digit_register),
  .out_segment_code_i   (out_o.segment_code),
  .out_last_write_i     (out_o.last_write)
);

/* bench/digit_write_checker.sv */
`timescale 1ns / 100ps

// Watches both channels. Predicts the eight digit writes of each request and
// compares them in order against what the block emits.
module digit_write_checker import dddw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  dddw_in_if          req_mon_i,
  dddw_out_if         wr_mon_i,
  output int unsigned mismatch_count_o,
  output int unsigned writes_pending_o
);

  localparam logic [CODE_W-1:0]  POINT_BIT    = 8'h80;
  localparam logic [VALUE_W-1:0] DECIMAL_BASE = 32'd10;
  localparam int unsigned        REPORT_MAX   = 10;

  typedef struct packed {
    logic [POS_W-1:0]  digit_register;
    logic [CODE_W-1:0] segment_code;
    logic              last_write;
  } digit_write_t;

  digit_write_t expected_writes[$];
  int unsigned  mismatches;

  // Eight writes, low digit first; blank above the point once digits run out.
  function automatic void queue_digit_writes(input logic [VALUE_W-1:0] value,
                                             input logic [POS_W-1:0]   point);
    logic [VALUE_W-1:0] rest;
    logic               exhausted;
    logic [CODE_W-1:0]  code;
    digit_write_t       wr;
    rest      = value;
    exhausted = 1'b0;
    for (int unsigned pos = 1; pos <= DIGIT_COUNT; pos++) begin
      if (exhausted) begin
        code = (pos <= point) ? {4'b0, CODE_ZERO} : {4'b0, CODE_BLANK};
      end else begin
        code = CODE_W'(rest % DECIMAL_BASE);
      end
      if (pos == point) begin
        code = code | POINT_BIT;
      end
      wr.digit_register = POS_W'(pos);
      wr.segment_code   = code;
      wr.last_write     = (pos == DIGIT_COUNT);
      expected_writes.push_back(wr);
      rest = rest / DECIMAL_BASE;
      if (rest == '0) begin
        exhausted = 1'b1;
      end
    end
  endfunction

  always @(posedge clk_i) begin
    digit_write_t exp_wr;
    if (rst_ni) begin
      if (wr_mon_i.valid && wr_mon_i.ready) begin
        if (expected_writes.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("%0t: unexpected digit write reg=%0d code=%0d last=%0b", $realtime,
                     wr_mon_i.digit_register, wr_mon_i.segment_code, wr_mon_i.last_write);
          end
        end else begin
          exp_wr = expected_writes.pop_front();
          if (exp_wr.digit_register !== wr_mon_i.digit_register ||
              exp_wr.segment_code !== wr_mon_i.segment_code ||
              exp_wr.last_write !== wr_mon_i.last_write) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("%0t: mismatch exp reg=%0d code=%0d last=%0b got %0d %0d %0b",
                       $realtime, exp_wr.digit_register, exp_wr.segment_code,
                       exp_wr.last_write, wr_mon_i.digit_register,
                       wr_mon_i.segment_code, wr_mon_i.last_write);
            end
          end
        end
      end
      if (req_mon_i.valid && req_mon_i.ready) begin
        queue_digit_writes(req_mon_i.value, req_mon_i.point_position);
      end
    end
    mismatch_count_o <= mismatches;
    writes_pending_o <= expected_writes.size();
  end

endmodule

/* bench/decimal_digit_display_writer_test.sv */
`timescale 1ns / 100ps

// Top of the bench: drives requests and write-side backpressure, leaves all
// prediction and comparison to the checker, and gives the verdict.
module decimal_digit_display_writer_test import dddw_pkg::*; ();

  localparam int unsigned RANDOM_REQUESTS = 248;
  localparam int unsigned DIRECTED_COUNT  = 22;
  localparam int unsigned CALM_FIRST      = 100;  // stretch with no idling
  localparam int unsigned CALM_LAST       = 140;
  localparam int unsigned DRAIN_AT        = 180;  // forced full drain
  localparam int unsigned SETTLE_CYCLES   = 24;

  // Directed corner cases: zero, all ones, a 9-digit value (top digit dropped),
  // point on a leading zero, point above the display, and round powers of ten.
  localparam logic [VALUE_W-1:0] DIRECTED_VALUES [DIRECTED_COUNT] = '{
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
    32'd1, 32'd9, 32'd10, 32'd5, 32'd7,
    32'd12345678, 32'd12345678, 32'd87654321, 32'd99999999, 32'd100000000,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'd1000, 32'd1000, 32'd305, 32'd10000000
  };
  localparam logic [POS_W-1:0] DIRECTED_POINTS [DIRECTED_COUNT] = '{
    4'd0, 4'd1, 4'd8, 4'd9, 4'd15,
    4'd0, 4'd1, 4'd0, 4'd3, 4'd8,
    4'd0, 4'd4, 4'd8, 4'd1, 4'd0,
    4'd0, 4'd8, 4'd15,
    4'd2, 4'd7, 4'd9, 4'd5
  };

  logic        clk_i;
  logic        rst_ni;
  bit          calm;
  int unsigned mismatch_count;
  int unsigned writes_pending;

  dddw_in_if  req_bus ();
  dddw_out_if wr_bus ();

  decimal_digit_display_writer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_bus),
    .out_o  (wr_bus)
  );

  digit_write_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_mon_i        (req_bus),
    .wr_mon_i         (wr_bus),
    .mismatch_count_o (mismatch_count),
    .writes_pending_o (writes_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Idle length for either side: mostly none, often short, now and then long.
  // During the calm stretch both sides run flat out.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Values spread over digit counts: tiny, mid, around powers of ten,
  // up to eight digits, and full 32-bit range (nine and ten digits).
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] pow10;
    int unsigned        exp10;
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 9);
      1: return $urandom_range(0, 9999);
      2: begin
        pow10 = 32'd1;
        exp10 = $urandom_range(0, 9);
        repeat (exp10) pow10 = pow10 * 32'd10;
        return pow10 - VALUE_W'($urandom_range(0, 1));
      end
      3: return $urandom_range(0, 99999999);
      default: return $urandom();
    endcase
  endfunction

  // Point mostly on the display, sometimes off it (9..15) so that bit 3 toggles.
  function automatic logic [POS_W-1:0] pick_point();
    if ($urandom_range(0, 9) != 0) begin
      return POS_W'($urandom_range(0, 8));
    end
    return POS_W'($urandom_range(9, 15));
  endfunction

  // One request: optional idle first, then hold valid until ready is seen.
  // valid is only lowered when a gap follows, so it never drops and rises
  // within the same step.
  task automatic send_request(input logic [VALUE_W-1:0] value,
                              input logic [POS_W-1:0]   point);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid          <= 1'b1;
    req_bus.value          <= value;
    req_bus.point_position <= point;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
  endtask

  // Stop sending until every predicted write has been seen. The first edge
  // lets the checker take the last request into account.
  task automatic wait_all_written();
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (writes_pending != 0) @(posedge clk_i);
  endtask

  // Write-side backpressure: bursts of ready broken by random stalls.
  initial begin : write_sink
    int unsigned run;
    int unsigned gap;
    wr_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      run = calm ? 16 : $urandom_range(1, 12);
      wr_bus.ready <= 1'b1;
      repeat (run) @(posedge clk_i);
      gap = pick_gap();
      if (gap != 0) begin
        wr_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    rst_ni                 <= 1'b0;
    calm                   = 1'b0;
    req_bus.valid          <= 1'b0;
    req_bus.value          <= '0;
    req_bus.point_position <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (int unsigned i = 0; i < DIRECTED_COUNT; i++) begin
      send_request(DIRECTED_VALUES[i], DIRECTED_POINTS[i]);
    end

    for (int unsigned i = 0; i < RANDOM_REQUESTS; i++) begin
      calm = (i >= CALM_FIRST) && (i < CALM_LAST);
      // Drain the pipe once for sure, and now and then at random.
      if (i == DRAIN_AT || $urandom_range(0, 49) == 0) begin
        wait_all_written();
      end
      send_request(pick_value(), pick_point());
    end

    // Everything sent; wait out the last writes, then watch for strays.
    calm = 1'b0;
    wait_all_written();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && writes_pending == 0) begin
      $display("decimal_digit_display_writer test passed");
    end else begin
      $display("decimal_digit_display_writer test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (every write behind a long
  // stall, every request behind a long gap).
  initial begin : watchdog
    #(5_000_000);
    $display("decimal_digit_display_writer test failed");
    $finish;
  end

endmodule
